/* sv/lfu_heap_replacement_top_defines.svh */
// Assertion macros used by the LFU heap replacement checker.
// Depends on nothing; the asserting module supplies clk_i and rst_ni.
`ifndef LFU_HEAP_REPLACEMENT_TOP_DEFINES_SVH
`define LFU_HEAP_REPLACEMENT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while reset is asserted
`define LFU_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while reset is asserted
`define LFU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* sv/lfu_hp_pkg.sv */
// Shared types and constants of the LFU heap replacement block.
// Used by the sequencer, the compare unit and the top level.
package lfu_hp_pkg;

  // Default sizes of the store
  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned KEY_BITS_DEF   = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Fixed widths of the ports
  localparam int unsigned IO_KEY_BITS = 16;
  localparam int unsigned IO_CNT_BITS = 16;
  localparam int unsigned CFG_BITS    = 5;

  localparam logic [CFG_BITS-1:0] CAP_RESET = 5'd16;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EV_ROOT,
    ST_EV_LAST,
    ST_SD_LEFT,
    ST_SD_RIGHT,
    ST_SD_CMP,
    ST_APPEND,
    ST_SU_RD,
    ST_SU_CMP,
    ST_FINISH
  } seq_state_e;

  // Flags from the shared compare unit
  typedef struct packed {
    logic lt;   // operand count below stored count
    logic eq;   // search key equals stored key
  } cmp_res_t;

  // One finished result
  typedef struct packed {
    logic                   hit;
    logic                   evicted;
    logic [IO_KEY_BITS-1:0] evicted_key;
    logic [IO_CNT_BITS-1:0] use_count;
  } out_res_t;

endpackage

/* sv/lfu_hp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfu_hp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, hold between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/lfu_hp_cmp.sv */
// Shared compare unit: count less-than, key equality, saturating increment.
// Depends on lfu_hp_pkg.
module lfu_hp_cmp #(
  parameter int unsigned KEY_BITS   = lfu_hp_pkg::KEY_BITS_DEF,
  parameter int unsigned COUNT_BITS = lfu_hp_pkg::COUNT_BITS_DEF
) (
  input  logic [COUNT_BITS-1:0] cnt_a_i,
  input  logic [COUNT_BITS-1:0] cnt_b_i,
  input  logic [KEY_BITS-1:0]   key_a_i,
  input  logic [KEY_BITS-1:0]   key_b_i,
  output lfu_hp_pkg::cmp_res_t  res_o,
  output logic [COUNT_BITS-1:0] inc_o
);
  import lfu_hp_pkg::*;

  assign res_o.lt = (cnt_a_i < cnt_b_i);
  assign res_o.eq = (key_a_i == key_b_i);

  // Stick at the top count
  assign inc_o = (&cnt_b_i) ? cnt_b_i : cnt_b_i + COUNT_BITS'(1);

endmodule

/* sv/lfu_hp_seq.sv */
// Sequencer of the LFU heap: key search, eviction, sift down and sift up.
// Depends on lfu_hp_pkg; drives the slot RAM and the shared compare unit.
module lfu_hp_seq #(
  parameter int unsigned CAPACITY   = lfu_hp_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS   = lfu_hp_pkg::KEY_BITS_DEF,
  parameter int unsigned COUNT_BITS = lfu_hp_pkg::COUNT_BITS_DEF,
  localparam int unsigned FILL_W    = $clog2(CAPACITY + 1),
  localparam int unsigned AW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned EW        = KEY_BITS + COUNT_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input items
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [lfu_hp_pkg::IO_KEY_BITS-1:0] block_key_i,
  // effective capacity and result hand-off
  input  logic [FILL_W-1:0]                  cap_i,
  input  logic                               out_free_i,
  output logic                               done_o,
  output lfu_hp_pkg::out_res_t               res_o,
  // slot RAM
  output logic                               ram_we_o,
  output logic [AW-1:0]                      ram_waddr_o,
  output logic [EW-1:0]                      ram_wdata_o,
  output logic                               ram_re_o,
  output logic [AW-1:0]                      ram_raddr_o,
  input  logic [EW-1:0]                      ram_rdata_i,
  // shared compare unit
  output logic [COUNT_BITS-1:0]              cnt_a_o,
  output logic [KEY_BITS-1:0]                key_a_o,
  input  lfu_hp_pkg::cmp_res_t               cmp_i,
  input  logic [COUNT_BITS-1:0]              inc_i
);
  import lfu_hp_pkg::*;

  seq_state_e state_q, state_d;

  logic [FILL_W-1:0]     node_q, node_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [KEY_BITS-1:0]   mov_key_q, mov_key_d;
  logic [COUNT_BITS-1:0] mov_cnt_q, mov_cnt_d;
  logic [KEY_BITS-1:0]   cand_key_q, cand_key_d;
  logic [COUNT_BITS-1:0] cand_cnt_q, cand_cnt_d;
  logic                  cand_child_q, cand_child_d;
  logic                  ret_append_q, ret_append_d;
  logic                  cmp_vld_q, cmp_vld_d;
  out_res_t              res_q, res_d;

  logic [KEY_BITS-1:0]   rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [FILL_W:0]       lc;
  logic [FILL_W:0]       rc;
  logic [FILL_W:0]       fill_x;
  logic [FILL_W-1:0]     fill_m1;
  logic [FILL_W-1:0]     parent;
  logic [EW-1:0]         mov_entry;

  assign rd_key    = ram_rdata_i[EW-1:COUNT_BITS];
  assign rd_cnt    = ram_rdata_i[COUNT_BITS-1:0];
  assign lc        = {node_q, 1'b1};
  assign rc        = lc + (FILL_W + 1)'(1);
  assign fill_x    = (FILL_W + 1)'(fill_q);
  assign fill_m1   = fill_q - FILL_W'(1);
  assign parent    = (node_q - FILL_W'(1)) >> 1;
  assign mov_entry = {mov_key_q, mov_cnt_q};

  // Compare unit operands: candidate count only when checking the right child
  assign cnt_a_o = (state_q == ST_SD_CMP) ? cand_cnt_q : mov_cnt_q;
  assign key_a_o = key_q;

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fill_q       <= '0;
      cmp_vld_q    <= 1'b0;
      ret_append_q <= 1'b0;
      cand_child_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      cmp_vld_q    <= cmp_vld_d;
      ret_append_q <= ret_append_d;
      cand_child_q <= cand_child_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    node_q     <= node_d;
    key_q      <= key_d;
    mov_key_q  <= mov_key_d;
    mov_cnt_q  <= mov_cnt_d;
    cand_key_q <= cand_key_d;
    cand_cnt_q <= cand_cnt_d;
    res_q      <= res_d;
  end

  // Next state, RAM requests and register updates
  always_comb begin
    state_d      = state_q;
    node_d       = node_q;
    fill_d       = fill_q;
    key_d        = key_q;
    mov_key_d    = mov_key_q;
    mov_cnt_d    = mov_cnt_q;
    cand_key_d   = cand_key_q;
    cand_cnt_d   = cand_cnt_q;
    cand_child_d = cand_child_q;
    ret_append_d = ret_append_q;
    cmp_vld_d    = 1'b0;
    res_d        = res_q;
    ram_we_o     = 1'b0;
    ram_waddr_o  = node_q[AW-1:0];
    ram_wdata_o  = mov_entry;
    ram_re_o     = 1'b0;
    ram_raddr_o  = node_q[AW-1:0];
    done_o       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d   = KEY_BITS'(block_key_i);
          node_d  = '0;
          res_d   = '0;
          state_d = ST_SEARCH;
        end
      end

      // Issue one slot read per cycle, compare the slot read in the previous cycle
      ST_SEARCH: begin
        if (cmp_vld_q && cmp_i.eq) begin
          mov_key_d           = key_q;
          mov_cnt_d           = inc_i;
          node_d              = node_q - FILL_W'(1);
          res_d.hit           = 1'b1;
          res_d.use_count     = IO_CNT_BITS'(inc_i);
          ret_append_d        = 1'b0;
          state_d             = ST_SD_LEFT;
        end else if (node_q == fill_q) begin
          res_d.use_count = IO_CNT_BITS'(1);
          if (fill_q >= cap_i && fill_q != '0) begin
            ram_re_o    = 1'b1;
            ram_raddr_o = '0;
            state_d     = ST_EV_ROOT;
          end else begin
            state_d = ST_APPEND;
          end
        end else begin
          ram_re_o  = 1'b1;
          node_d    = node_q + FILL_W'(1);
          cmp_vld_d = 1'b1;
        end
      end

      // Report the root, fetch the last slot
      ST_EV_ROOT: begin
        res_d.evicted     = 1'b1;
        res_d.evicted_key = IO_KEY_BITS'(rd_key);
        fill_d            = fill_m1;
        ram_re_o          = 1'b1;
        ram_raddr_o       = fill_m1[AW-1:0];
        state_d           = ST_EV_LAST;
      end

      ST_EV_LAST: begin
        mov_key_d    = rd_key;
        mov_cnt_d    = rd_cnt;
        node_d       = '0;
        ret_append_d = 1'b1;
        state_d      = ST_SD_LEFT;
      end

      // Sift down: fetch left child or drop the moving entry into the hole
      ST_SD_LEFT: begin
        if (lc >= fill_x) begin
          ram_we_o = 1'b1;
          state_d  = ret_append_q ? ST_APPEND : ST_FINISH;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = lc[AW-1:0];
          state_d     = ST_SD_RIGHT;
        end
      end

      // Left child is in; a tie goes to the child
      ST_SD_RIGHT: begin
        cand_child_d = !cmp_i.lt;
        cand_key_d   = cmp_i.lt ? mov_key_q : rd_key;
        cand_cnt_d   = cmp_i.lt ? mov_cnt_q : rd_cnt;
        if (rc < fill_x) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = rc[AW-1:0];
          state_d     = ST_SD_CMP;
        end else if (cmp_i.lt) begin
          ram_we_o = 1'b1;
          state_d  = ret_append_q ? ST_APPEND : ST_FINISH;
        end else begin
          ram_we_o    = 1'b1;
          ram_wdata_o = ram_rdata_i;
          node_d      = FILL_W'(lc);
          state_d     = ST_SD_LEFT;
        end
      end

      // Right child is in; a tie goes to the right child
      ST_SD_CMP: begin
        ram_we_o = 1'b1;
        if (cmp_i.lt && !cand_child_q) begin
          state_d = ret_append_q ? ST_APPEND : ST_FINISH;
        end else if (cmp_i.lt) begin
          ram_wdata_o = {cand_key_q, cand_cnt_q};
          node_d      = FILL_W'(lc);
          state_d     = ST_SD_LEFT;
        end else begin
          ram_wdata_o = ram_rdata_i;
          node_d      = FILL_W'(rc);
          state_d     = ST_SD_LEFT;
        end
      end

      // Place the new key at the end with count one
      ST_APPEND: begin
        mov_key_d = key_q;
        mov_cnt_d = COUNT_BITS'(1);
        node_d    = fill_q;
        fill_d    = fill_q + FILL_W'(1);
        state_d   = ST_SU_RD;
      end

      // Sift up: fetch parent or settle at the root
      ST_SU_RD: begin
        if (node_q == '0) begin
          ram_we_o = 1'b1;
          state_d  = ST_FINISH;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = parent[AW-1:0];
          state_d     = ST_SU_CMP;
        end
      end

      // Move parent down only while its count is strictly greater
      ST_SU_CMP: begin
        ram_we_o = 1'b1;
        if (cmp_i.lt) begin
          ram_wdata_o = ram_rdata_i;
          node_d      = parent;
          state_d     = ST_SU_RD;
        end else begin
          state_d = ST_FINISH;
        end
      end

      // Hand the result over once the output register is free
      ST_FINISH: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign res_o      = res_q;

endmodule

/* sv/lfu_heap_replacement_top.sv */
// Top level of the LFU heap replacement block: capacity register, output register.
// Depends on lfu_hp_pkg, lfu_hp_seq, lfu_hp_cmp and lfu_hp_ram.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------------
//   in      | in        | in_valid_i / in_stall_o | block_key_i
//   out     | out       | out_valid_o/ out_stall_i| hit_o, evicted_o, evicted_key_o, use_count_o
//   cfg     | in        | cfg_valid_i/ cfg_ready_o| cfg_data_i (active_capacity)
//
// One item at a time. Steps per item: accept, key search through the single RAM read port,
// evict when full, sift down level by level, append, sift up level by level, hand over.
// Reset clears the fill level, the sequencer and the output valid; slot contents are
// not cleared, only slots below the fill level are read. A stalled output holds its
// beat; the next item is taken meanwhile and waits at its end for the register.
module lfu_heap_replacement_top #(
  parameter int unsigned CAPACITY   = lfu_hp_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS   = lfu_hp_pkg::KEY_BITS_DEF,
  parameter int unsigned COUNT_BITS = lfu_hp_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [lfu_hp_pkg::IO_KEY_BITS-1:0] block_key_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               hit_o,
  output logic                               evicted_o,
  output logic [lfu_hp_pkg::IO_KEY_BITS-1:0] evicted_key_o,
  output logic [lfu_hp_pkg::IO_CNT_BITS-1:0] use_count_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lfu_hp_pkg::CFG_BITS-1:0]    cfg_data_i
);
  import lfu_hp_pkg::*;

  localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
  localparam int unsigned AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned EW     = KEY_BITS + COUNT_BITS;
  localparam int unsigned CW     = (FILL_W > CFG_BITS) ? FILL_W : CFG_BITS;

  logic [CFG_BITS-1:0]   cap_q;
  logic [CW-1:0]         cap_w;
  logic [FILL_W-1:0]     cap_eff;
  logic                  out_valid_q;
  out_res_t              out_q;
  out_res_t              res;
  logic                  done;
  logic                  out_free;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [EW-1:0]         ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [EW-1:0]         ram_rdata;
  logic [COUNT_BITS-1:0] cnt_a;
  logic [KEY_BITS-1:0]   key_a;
  cmp_res_t              cmp_res;
  logic [COUNT_BITS-1:0] inc;

  // Capacity register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // Clamp capacity to one .. CAPACITY
  assign cap_w = CW'(cap_q);

  always_comb begin
    if (cap_w == '0) begin
      cap_eff = FILL_W'(1);
    end else if (cap_w > CW'(CAPACITY)) begin
      cap_eff = FILL_W'(CAPACITY);
    end else begin
      cap_eff = FILL_W'(cap_w);
    end
  end

  // Output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_q.hit;
  assign evicted_o     = out_q.evicted;
  assign evicted_key_o = out_q.evicted_key;
  assign use_count_o   = out_q.use_count;

  lfu_hp_seq #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .block_key_i (block_key_i),
    .cap_i       (cap_eff),
    .out_free_i  (out_free),
    .done_o      (done),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .cnt_a_o     (cnt_a),
    .key_a_o     (key_a),
    .cmp_i       (cmp_res),
    .inc_i       (inc)
  );

  lfu_hp_cmp #(
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_cmp (
    .cnt_a_i (cnt_a),
    .cnt_b_i (ram_rdata[COUNT_BITS-1:0]),
    .key_a_i (key_a),
    .key_b_i (ram_rdata[EW-1:COUNT_BITS]),
    .res_o   (cmp_res),
    .inc_o   (inc)
  );

  lfu_hp_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

/* sv/lfu_hp_chk.sv */
// Port-level checker for the LFU heap replacement top level, with its bind.
// Depends on lfu_hp_pkg and lfu_heap_replacement_top_defines.svh.
`include "lfu_heap_replacement_top_defines.svh"

module lfu_hp_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic                               hit_o,
  input logic                               evicted_o,
  input logic [lfu_hp_pkg::IO_KEY_BITS-1:0] evicted_key_o,
  input logic [lfu_hp_pkg::IO_CNT_BITS-1:0] use_count_o
);
  import lfu_hp_pkg::*;

  // Busy right after taking an item
  `LFU_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "not busy after accept")

  // A miss always reports a count of one
  `LFU_ASSERT_NOW(a_miss_count_one, out_valid_o && !hit_o, use_count_o == IO_CNT_BITS'(1), "miss count not one")

  // No eviction on a hit, and no evicted key without an eviction
  `LFU_ASSERT_NOW(a_hit_no_evict, out_valid_o && hit_o, !evicted_o, "eviction on a hit")
  `LFU_ASSERT_NOW(a_evkey_zero, out_valid_o && !evicted_o, evicted_key_o == '0, "stray evicted key")

  // A stalled result beat holds
  `LFU_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(use_count_o) && $stable(evicted_key_o), "stalled beat changed")

endmodule

bind lfu_heap_replacement_top lfu_hp_chk u_lfu_hp_chk (.*);

/* bench/lfu_heap_replacement_top_tb.sv */
// Self-checking bench for the LFU heap replacement block: directed and random references.
// Depends on lfu_hp_pkg and lfu_heap_replacement_top; predicts every result with its own heap.
`timescale 1ns / 1ps

module lfu_heap_replacement_top_tb;

  localparam int unsigned SLOTS       = lfu_hp_pkg::CAPACITY_DEF;
  localparam int unsigned KEY_W       = lfu_hp_pkg::IO_KEY_BITS;
  localparam int unsigned CNT_W       = lfu_hp_pkg::IO_CNT_BITS;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam int unsigned POOL_SIZE   = 20;
  localparam int unsigned TAIL_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned MAX_REPORTS = 40;
  localparam int unsigned SAT_REFS    = 20;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall_o;
  logic [KEY_W-1:0]                block_key = '0;
  logic                            out_valid_o;
  logic                            out_stall = 1'b0;
  logic                            hit_o;
  logic                            evicted_o;
  logic [KEY_W-1:0]                evicted_key_o;
  logic [CNT_W-1:0]                use_count_o;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready_o;
  logic [lfu_hp_pkg::CFG_BITS-1:0] cfg_data = '0;

  // Shadow heap of the store
  logic [KEY_W-1:0]                heap_key [SLOTS];
  logic [CNT_W-1:0]                heap_cnt [SLOTS];
  int unsigned                     heap_fill = 0;
  logic [lfu_hp_pkg::CFG_BITS-1:0] cap_shadow = lfu_hp_pkg::CAP_RESET;

  logic [KEY_W-1:0]       keys_to_send [$];
  lfu_hp_pkg::out_res_t   outcomes_due [$];
  lfu_hp_pkg::out_res_t   oldest_outcome;
  logic [KEY_W-1:0]       key_pool [POOL_SIZE];
  int unsigned            send_gap_pct = 25;
  int unsigned            recv_stall_pct = 52;
  int unsigned            errors = 0;
  int unsigned            cycle_count;

  lfu_heap_replacement_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .block_key_i   (block_key),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .hit_o         (hit_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o),
    .use_count_o   (use_count_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic void heap_swap(input int unsigned a, input int unsigned b);
    logic [KEY_W-1:0] k;
    logic [CNT_W-1:0] c;
    k = heap_key[a];
    c = heap_cnt[a];
    heap_key[a] = heap_key[b];
    heap_cnt[a] = heap_cnt[b];
    heap_key[b] = k;
    heap_cnt[b] = c;
  endfunction

  // Push a node down; a tie hands the place to the child
  function automatic void sift_down_from(input int unsigned node, input int unsigned n);
    int unsigned lc;
    int unsigned rc;
    int unsigned best;
    while (node < n) begin
      lc = 2 * node + 1;
      rc = lc + 1;
      best = node;
      if (lc < n) best = (heap_cnt[node] < heap_cnt[lc]) ? node : lc;
      if (rc < n) best = (heap_cnt[best] < heap_cnt[rc]) ? best : rc;
      if (best == node) break;
      heap_swap(best, node);
      node = best;
    end
  endfunction

  // Apply one reference to the shadow heap and return the result it yields
  function automatic lfu_hp_pkg::out_res_t reference_block(input logic [KEY_W-1:0] key);
    lfu_hp_pkg::out_res_t res;
    int unsigned cap;
    int unsigned slot;
    int unsigned up;
    int unsigned i;
    bit found;
    res = '0;
    cap = cap_shadow;
    if (cap < 1) cap = 1;
    if (cap > SLOTS) cap = SLOTS;
    found = 1'b0;
    slot = 0;
    for (i = 0; i < heap_fill && !found; i++) begin
      if (heap_key[i] == key) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (found) begin
      if (heap_cnt[slot] != CNT_MAX) heap_cnt[slot] = heap_cnt[slot] + 1'b1;
      res.hit = 1'b1;
      res.use_count = heap_cnt[slot];
      sift_down_from(slot, heap_fill);
      return res;
    end
    // Full store: drop the root, refill it from the last slot
    if (heap_fill >= cap && heap_fill > 0) begin
      res.evicted = 1'b1;
      res.evicted_key = heap_key[0];
      heap_fill--;
      heap_key[0] = heap_key[heap_fill];
      heap_cnt[0] = heap_cnt[heap_fill];
      sift_down_from(0, heap_fill);
    end
    // Append with count one and climb while the parent is strictly larger
    slot = heap_fill;
    heap_key[slot] = key;
    heap_cnt[slot] = CNT_W'(1);
    heap_fill++;
    while (slot > 0) begin
      up = (slot - 1) / 2;
      if (!(heap_cnt[up] > heap_cnt[slot])) break;
      heap_swap(up, slot);
      slot = up;
    end
    res.use_count = CNT_W'(1);
    return res;
  endfunction

  // Input driver: predict on each accepted beat, hold a stalled beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      block_key <= '0;
    end else begin
      if (in_valid && !in_stall_o) outcomes_due.push_back(reference_block(block_key));
      if (!in_valid || !in_stall_o) begin
        if (keys_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid  <= 1'b1;
          block_key <= keys_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string field, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // Output monitor: compare each accepted beat with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (outcomes_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual hit=%0b use_count=%0h",
                     $time, hit_o, use_count_o);
        end else begin
          oldest_outcome = outcomes_due.pop_front();
          check_field("hit", CNT_W'(oldest_outcome.hit), CNT_W'(hit_o));
          check_field("evicted", CNT_W'(oldest_outcome.evicted), CNT_W'(evicted_o));
          check_field("evicted_key", oldest_outcome.evicted_key, evicted_key_o);
          check_field("use_count", oldest_outcome.use_count, use_count_o);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Give up on a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("lfu_heap_replacement_top_tb: done, errors");
    $finish;
  end

  // Wait until every queued reference has been sent and answered
  task automatic wait_drained();
    while (keys_to_send.size() != 0 || outcomes_due.size() != 0 || in_valid)
      @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [lfu_hp_pkg::CFG_BITS-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cap_shadow = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic refresh_pool();
    int unsigned i;
    for (i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
  endtask

  // Mostly revisit a small working set so hits, ties and evictions are common
  task automatic queue_random(input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(99) < 70) keys_to_send.push_back(key_pool[$urandom_range(POOL_SIZE - 1)]);
      else keys_to_send.push_back(KEY_W'($urandom));
    end
  endtask

  initial begin
    int unsigned i;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero capacity acts as one; hit one key over and over, then replace it
    write_capacity(5'd0);
    for (i = 0; i < SAT_REFS; i++) keys_to_send.push_back(16'h1234);
    keys_to_send.push_back(16'h4321);

    // Small capacity: fill, evict, and hit to build equal counts
    write_capacity(5'd4);
    keys_to_send.push_back(16'h0000);
    keys_to_send.push_back(16'hFFFF);
    keys_to_send.push_back(16'h0000);
    keys_to_send.push_back(16'h8000);
    keys_to_send.push_back(16'h7FFF);
    keys_to_send.push_back(16'hFFFF);
    keys_to_send.push_back(16'h8000);
    keys_to_send.push_back(16'h7FFF);

    // Oversized capacity saturates to the full store; fill it and evict
    write_capacity(5'd31);
    for (i = 0; i < 12; i++) keys_to_send.push_back(16'h0001 << i);
    keys_to_send.push_back(16'hFFFE);
    keys_to_send.push_back(16'h0004);

    // Capacity below the fill level: each miss evicts the root once
    write_capacity(5'd3);
    keys_to_send.push_back(16'hA5A5);
    keys_to_send.push_back(16'h5A5A);

    // Random references, with a full pause halfway
    write_capacity(5'd2);
    refresh_pool();
    queue_random(130);
    wait_drained();
    queue_random(130);

    // Swap the idle rates
    write_capacity(5'd16);
    send_gap_pct   = 52;
    recv_stall_pct = 25;
    refresh_pool();
    queue_random(270);

    // No idling on either side
    write_capacity(5'($urandom_range(17, 31)));
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    refresh_pool();
    queue_random(140);
    write_capacity(5'd1);
    queue_random(140);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && outcomes_due.size() == 0) begin
      $display("lfu_heap_replacement_top_tb: done, clean");
    end else begin
      $display("lfu_heap_replacement_top_tb: done, errors");
    end
    $finish;
  end

endmodule
